// ===== hdl/wfcd_pkg.sv =====
// Package for the wait-for cycle detector: sizes, codes, control words and the program ROM.
`timescale 1ns / 1ps

package wfcd_pkg;

   // Table geometry
   localparam int NUM_PROC = 16;
   localparam int PID_W    = 4;
   localparam int CNT_W    = 5;
   localparam logic [CNT_W-1:0] NUM_PROC_CNT = CNT_W'(NUM_PROC);

   // Visit colors
   typedef logic [1:0] color_type;
   localparam color_type COLOR_NONE = 2'd0;
   localparam color_type COLOR_PATH = 2'd1;
   localparam color_type COLOR_DONE = 2'd2;

   // Datapath operations
   typedef logic [3:0] op_type;
   localparam op_type OP_NOP       = 4'd0;
   localparam op_type OP_ACCEPT    = 4'd1;
   localparam op_type OP_CLEAR     = 4'd2;
   localparam op_type OP_SCAN      = 4'd3;
   localparam op_type OP_WALK      = 4'd4;
   localparam op_type OP_FINISH    = 4'd5;
   localparam op_type OP_ADVANCE   = 4'd6;
   localparam op_type OP_OSEL      = 4'd7;
   localparam op_type OP_CYCLE     = 4'd8;
   localparam op_type OP_EMIT      = 4'd9;
   localparam op_type OP_EMIT_NONE = 4'd10;
   localparam op_type OP_SET       = 4'd11;

   // Jump conditions
   typedef logic [3:0] cond_type;
   localparam cond_type COND_NEVER     = 4'd0;
   localparam cond_type COND_ALWAYS    = 4'd1;
   localparam cond_type COND_SET       = 4'd2;
   localparam cond_type COND_COLORED   = 4'd3;
   localparam cond_type COND_WALK_ON   = 4'd4;
   localparam cond_type COND_SCAN_MORE = 4'd5;
   localparam cond_type COND_NO_PEND   = 4'd6;
   localparam cond_type COND_PEND      = 4'd7;
   localparam cond_type COND_SKIP_ORG  = 4'd8;
   localparam cond_type COND_CYC_ON    = 4'd9;
   localparam cond_type COND_INC_MORE  = 4'd10;

   // Program steps
   typedef logic [3:0] step_type;
   localparam step_type ST_IDLE  = 4'd0;
   localparam step_type ST_CLR   = 4'd1;
   localparam step_type ST_SCAN  = 4'd2;
   localparam step_type ST_WALK  = 4'd3;
   localparam step_type ST_FIN   = 4'd4;
   localparam step_type ST_NEXT  = 4'd5;
   localparam step_type ST_CHK   = 4'd6;
   localparam step_type ST_OSEL  = 4'd7;
   localparam step_type ST_CYC   = 4'd8;
   localparam step_type ST_EMIT  = 4'd9;
   localparam step_type ST_AFTER = 4'd10;
   localparam step_type ST_DONE  = 4'd11;
   localparam step_type ST_NONE  = 4'd12;
   localparam step_type ST_SET   = 4'd13;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctl_word_type;

   // Condition flags from the datapath to the sequencer
   typedef struct packed {
      logic set_mode;
      logic colored;
      logic walk_on;
      logic scan_more;
      logic pend_any;
      logic skip_org;
      logic cyc_on;
      logic inc_more;
   } stat_type;

   // Program ROM: one control word per step
   function automatic ctl_word_type rom_word(input step_type pc);
      ctl_word_type w;
      w = '{op: OP_NOP, cond: COND_ALWAYS, target: ST_IDLE};
      case (pc)
         ST_IDLE:  w = '{op: OP_ACCEPT,    cond: COND_SET,       target: ST_SET};
         ST_CLR:   w = '{op: OP_CLEAR,     cond: COND_NEVER,     target: ST_IDLE};
         ST_SCAN:  w = '{op: OP_SCAN,      cond: COND_COLORED,   target: ST_NEXT};
         ST_WALK:  w = '{op: OP_WALK,      cond: COND_WALK_ON,   target: ST_WALK};
         ST_FIN:   w = '{op: OP_FINISH,    cond: COND_NEVER,     target: ST_IDLE};
         ST_NEXT:  w = '{op: OP_ADVANCE,   cond: COND_SCAN_MORE, target: ST_SCAN};
         ST_CHK:   w = '{op: OP_NOP,       cond: COND_NO_PEND,   target: ST_NONE};
         ST_OSEL:  w = '{op: OP_OSEL,      cond: COND_SKIP_ORG,  target: ST_OSEL};
         ST_CYC:   w = '{op: OP_CYCLE,     cond: COND_CYC_ON,    target: ST_CYC};
         ST_EMIT:  w = '{op: OP_EMIT,      cond: COND_INC_MORE,  target: ST_EMIT};
         ST_AFTER: w = '{op: OP_NOP,       cond: COND_PEND,      target: ST_OSEL};
         ST_DONE:  w = '{op: OP_NOP,       cond: COND_ALWAYS,    target: ST_IDLE};
         ST_NONE:  w = '{op: OP_EMIT_NONE, cond: COND_ALWAYS,    target: ST_IDLE};
         ST_SET:   w = '{op: OP_SET,       cond: COND_ALWAYS,    target: ST_IDLE};
         default:  w = '{op: OP_NOP,       cond: COND_ALWAYS,    target: ST_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/wait_for_cycle_detector.sv =====
// Top level of the wait-for cycle detector: table, visit state, report logic, handshakes.
`timescale 1ns / 1ps

// Wait-for cycle detector. A set word (mode 0) writes one entry of a 16-entry
// wait-for table and is answered by one acknowledge word. A detect word
// (mode 1) walks the table from every unvisited process in ascending order,
// collects the origin of each cycle it meets, and then reports every cycle
// whose origin was never reported before: its members in ascending order,
// last_in_cycle on the highest member and last on the final word. A detect
// with nothing new answers with one word with found = 0. Items are handled
// one at a time by a microcoded sequencer that follows one table entry per
// clock. A set item is accepted, then written and acknowledged. A detect
// clears the visit state, scans each process, walks from each unvisited one
// and retires its path, then takes each collected origin in turn, traces the
// cycle of each new one and emits its members, skipping origins reported
// before. Result words wait in an output register; the sequencer stalls only
// when that register is still full.
module wait_for_cycle_detector import wfcd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_mode,
   input  logic [PID_W-1:0] req_process_id,
   input  logic [PID_W-1:0] req_waits_on,
   input  logic             req_waiting,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_found,
   output logic [PID_W-1:0] rsp_member,
   output logic [PID_W-1:0] rsp_cycle_origin,
   output logic             rsp_last_in_cycle,
   output logic             rsp_last
);

   ctl_word_type ctl;
   stat_type     stat;
   logic         go;
   logic         slot_free;
   logic         emit_go;

   // Architectural state
   logic [PID_W:0]    table_ff [NUM_PROC];
   logic [PID_W:0]    table_in [NUM_PROC];
   color_type         color_ff [NUM_PROC];
   color_type         color_in [NUM_PROC];
   logic [NUM_PROC-1:0] mark_ff, mark_in;
   logic [NUM_PROC-1:0] pend_ff, pend_in;
   logic [PID_W-1:0]  list_ff [NUM_PROC];
   logic [PID_W-1:0]  list_in [NUM_PROC];
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PID_W-1:0]  oidx_ff, oidx_in;

   // Working registers
   logic [PID_W-1:0]  start_ff, start_in;
   logic [PID_W-1:0]  node_ff, node_in;
   logic [PID_W-1:0]  origin_ff, origin_in;
   logic [PID_W-1:0]  hi_ff, hi_in;
   logic [NUM_PROC-1:0] inc_ff, inc_in;

   // Captured request
   logic [PID_W-1:0] pid_ff, pid_in;
   logic [PID_W-1:0] tgt_ff, tgt_in;
   logic             wait_ff, wait_in;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             found_ff, found_in;
   logic [PID_W-1:0] member_ff, member_in;
   logic [PID_W-1:0] org_out_ff, org_out_in;
   logic             lic_ff, lic_in;
   logic             last_ff, last_in;

   // Combinational helpers
   logic [PID_W:0]      entry;
   logic [PID_W-1:0]    nxt;
   color_type           nxt_color;
   logic [PID_W-1:0]    list_head;
   logic [NUM_PROC-1:0] low_bit;
   logic [NUM_PROC-1:0] inc_rest;
   logic [PID_W-1:0]    low_idx;
   logic                path_any;

   wfcd_seq u_seq (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .stat  (stat),
      .ctl   (ctl)
   );

   // Handshake and stall control
   assign req_ready = (ctl.op == OP_ACCEPT);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (ctl.op)
         OP_ACCEPT:                    go = req_valid;
         OP_EMIT, OP_EMIT_NONE, OP_SET: go = slot_free;
         default:                      go = 1'b1;
      endcase
   end

   assign emit_go = go && (ctl.op == OP_EMIT || ctl.op == OP_EMIT_NONE || ctl.op == OP_SET);

   // Single table read port, addressed by the walk pointer
   assign entry     = table_ff[node_ff];
   assign nxt       = entry[PID_W-1:0];
   assign nxt_color = (nxt == node_ff) ? COLOR_PATH : color_ff[nxt];
   assign list_head = list_ff[oidx_ff];

   // Pick the lowest remaining cycle member
   assign low_bit  = inc_ff & (~inc_ff + NUM_PROC'(1));
   assign inc_rest = inc_ff & ~low_bit;

   always_comb begin
      low_idx = '0;
      for (int i = 0; i < NUM_PROC; i++) begin
         if (low_bit[i]) begin
            low_idx = PID_W'(i);
         end
      end
   end

   always_comb begin
      path_any = 1'b0;
      for (int i = 0; i < NUM_PROC; i++) begin
         if (color_ff[i] == COLOR_PATH) begin
            path_any = 1'b1;
         end
      end
   end

   // Condition flags for the sequencer
   always_comb begin
      stat.set_mode  = !req_mode;
      stat.colored   = (color_ff[start_ff] != COLOR_NONE);
      stat.walk_on   = entry[PID_W] && (nxt_color == COLOR_NONE);
      stat.scan_more = (start_ff != PID_W'(NUM_PROC - 1));
      stat.pend_any  = |pend_ff;
      stat.skip_org  = !pend_ff[list_head];
      stat.cyc_on    = entry[PID_W] && (nxt != origin_ff);
      stat.inc_more  = |inc_rest;
   end

   // Datapath: carry out the operation of the current step
   always_comb begin
      table_in  = table_ff;
      color_in  = color_ff;
      mark_in   = mark_ff;
      pend_in   = pend_ff;
      list_in   = list_ff;
      cnt_in    = cnt_ff;
      oidx_in   = oidx_ff;
      start_in  = start_ff;
      node_in   = node_ff;
      origin_in = origin_ff;
      hi_in     = hi_ff;
      inc_in    = inc_ff;
      pid_in    = pid_ff;
      tgt_in    = tgt_ff;
      wait_in   = wait_ff;
      unique case (ctl.op)
         OP_ACCEPT: begin
            // capture the request word
            if (req_valid) begin
               pid_in  = req_process_id;
               tgt_in  = req_waits_on;
               wait_in = req_waiting;
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < NUM_PROC; i++) begin
               color_in[i] = COLOR_NONE;
            end
            pend_in  = '0;
            cnt_in   = '0;
            oidx_in  = '0;
            start_in = '0;
         end
         OP_SCAN: begin
            node_in = start_ff;
         end
         OP_WALK: begin
            // color this node and follow its edge
            color_in[node_ff] = COLOR_PATH;
            if (entry[PID_W]) begin
               if (nxt_color == COLOR_NONE) begin
                  node_in = nxt;
               end else if (nxt_color == COLOR_PATH && cnt_ff < NUM_PROC_CNT) begin
                  list_in[cnt_ff[PID_W-1:0]] = nxt;
                  cnt_in                     = cnt_ff + CNT_W'(1);
                  pend_in[nxt]               = !mark_ff[nxt];
               end
            end
         end
         OP_FINISH: begin
            for (int i = 0; i < NUM_PROC; i++) begin
               if (color_ff[i] == COLOR_PATH) begin
                  color_in[i] = COLOR_DONE;
               end
            end
         end
         OP_ADVANCE: begin
            start_in = start_ff + PID_W'(1);
         end
         OP_OSEL: begin
            // take the next origin from the list; mark it if it is new
            oidx_in   = oidx_ff + PID_W'(1);
            origin_in = list_head;
            node_in   = list_head;
            inc_in    = '0;
            hi_in     = '0;
            if (pend_ff[list_head]) begin
               mark_in[list_head] = 1'b1;
               pend_in[list_head] = 1'b0;
            end
         end
         OP_CYCLE: begin
            inc_in[node_ff] = 1'b1;
            if (node_ff > hi_ff) begin
               hi_in = node_ff;
            end
            node_in = nxt;
         end
         OP_EMIT: begin
            if (go) begin
               inc_in = inc_rest;
            end
         end
         OP_SET: begin
            // write one table entry; drop out-of-range targets
            if (go && {1'b0, pid_ff} < NUM_PROC_CNT) begin
               if (!wait_ff) begin
                  table_in[pid_ff] = '0;
               end else if ({1'b0, tgt_ff} < NUM_PROC_CNT) begin
                  table_in[pid_ff] = {1'b1, tgt_ff};
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Output register: load a word when the step emits, drop it when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      member_in    = member_ff;
      org_out_in   = org_out_ff;
      lic_in       = lic_ff;
      last_in      = last_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         if (ctl.op == OP_EMIT) begin
            found_in   = 1'b1;
            member_in  = low_idx;
            org_out_in = origin_ff;
            lic_in     = (low_idx == hi_ff);
            last_in    = (inc_rest == '0) && (pend_ff == '0);
         end else begin
            found_in   = 1'b0;
            member_in  = '0;
            org_out_in = '0;
            lic_in     = 1'b0;
            last_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PROC; i++) begin
            table_ff[i] <= '0;
            color_ff[i] <= COLOR_NONE;
         end
         mark_ff      <= '0;
         pend_ff      <= '0;
         cnt_ff       <= '0;
         oidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         table_ff     <= table_in;
         color_ff     <= color_in;
         mark_ff      <= mark_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         oidx_ff      <= oidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      list_ff    <= list_in;
      start_ff   <= start_in;
      node_ff    <= node_in;
      origin_ff  <= origin_in;
      hi_ff      <= hi_in;
      inc_ff     <= inc_in;
      pid_ff     <= pid_in;
      tgt_ff     <= tgt_in;
      wait_ff    <= wait_in;
      found_ff   <= found_in;
      member_ff  <= member_in;
      org_out_ff <= org_out_in;
      lic_ff     <= lic_in;
      last_ff    <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_member        = member_ff;
   assign rsp_cycle_origin  = org_out_ff;
   assign rsp_last_in_cycle = lic_ff;
   assign rsp_last          = last_ff;

   // An origin waiting to be reported never carries a reported mark
   a_pend_unmarked: assert property (@(posedge clock) disable iff (reset)
      (pend_ff & mark_ff) == '0)
      else $error("pending origin already marked");

   // Every walk starts with no node left on a path
   a_scan_clean: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_SCAN |-> !path_any)
      else $error("path color left over at scan");

   // A word without a member is always final and carries zero fields
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && !rsp_last_in_cycle && rsp_member == '0)
      else $error("malformed empty result word");

   // No new request is taken while a detect still has cycles to report
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> pend_ff == '0)
      else $error("request accepted with reports outstanding");

endmodule

// ===== hdl/wfcd_seq.sv =====
// Microcode sequencer: step counter, program ROM and conditional jumps.
`timescale 1ns / 1ps

module wfcd_seq import wfcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  stat_type     stat,
   output ctl_word_type ctl
);

   step_type pc_ff;
   step_type pc_in;
   logic     taken;

   // Fetch the control word of the current step
   assign ctl = rom_word(pc_ff);

   // Evaluate the jump condition
   always_comb begin
      unique case (ctl.cond)
         COND_NEVER:     taken = 1'b0;
         COND_ALWAYS:    taken = 1'b1;
         COND_SET:       taken = stat.set_mode;
         COND_COLORED:   taken = stat.colored;
         COND_WALK_ON:   taken = stat.walk_on;
         COND_SCAN_MORE: taken = stat.scan_more;
         COND_NO_PEND:   taken = !stat.pend_any;
         COND_PEND:      taken = stat.pend_any;
         COND_SKIP_ORG:  taken = stat.skip_org;
         COND_CYC_ON:    taken = stat.cyc_on;
         COND_INC_MORE:  taken = stat.inc_more;
         default:        taken = 1'b0;
      endcase
   end

   // Advance, jump or hold the step counter
   always_comb begin
      pc_in = pc_ff;
      if (go) begin
         pc_in = taken ? ctl.target : pc_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== tb/wait_for_cycle_checker.sv =====
// Checker for the wait-for cycle detector: mirrors the table, predicts and compares result words.
`timescale 1ns / 1ps

module wait_for_cycle_checker import wfcd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic             req_mode,
   input  logic [PID_W-1:0] req_process_id,
   input  logic [PID_W-1:0] req_waits_on,
   input  logic             req_waiting,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             rsp_found,
   input  logic [PID_W-1:0] rsp_member,
   input  logic [PID_W-1:0] rsp_cycle_origin,
   input  logic             rsp_last_in_cycle,
   input  logic             rsp_last,
   output int               mismatches,
   output int               outstanding
);

   localparam int MAX_WORDS = 16;

   typedef struct packed {
      logic             found;
      logic [PID_W-1:0] member;
      logic [PID_W-1:0] origin;
      logic             closes_cycle;
      logic             final_word;
   } cycle_word_type;

   // Mirror of the wait-for table: bit PID_W = waiting, low bits = target
   logic [PID_W:0] wait_entry [NUM_PROC];
   logic           origin_marked [NUM_PROC];
   cycle_word_type awaited_words [$];

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Walk the table, collect cycle origins, queue words for every new cycle
   task automatic predict_detect();
      color_type      color [NUM_PROC];
      int             origins [$];
      cycle_word_type batch [$];
      cycle_word_type w;
      logic [NUM_PROC-1:0] in_cycle;
      int             node;
      int             nxt;
      int             org;
      int             hi;
      foreach (color[i]) color[i] = COLOR_NONE;
      for (int start = 0; start < NUM_PROC; start++) begin
         if (color[start] == COLOR_NONE) begin
            // follow the chain until it ends, meets a finished node or closes
            node = start;
            for (int s = 0; s <= NUM_PROC; s++) begin
               color[node] = COLOR_PATH;
               if (!wait_entry[node][PID_W]) break;
               nxt = wait_entry[node][PID_W-1:0];
               if (color[nxt] == COLOR_DONE) break;
               if (color[nxt] == COLOR_PATH) begin
                  origins.push_back(nxt);
                  break;
               end
               node = nxt;
            end
            // retire every node of this walk
            node = start;
            for (int s = 0; s <= NUM_PROC; s++) begin
               if (color[node] != COLOR_PATH) break;
               color[node] = COLOR_DONE;
               if (!wait_entry[node][PID_W]) break;
               node = wait_entry[node][PID_W-1:0];
            end
         end
      end
      // report each unmarked origin once, members in ascending order
      foreach (origins[c]) begin
         org = origins[c];
         if (origin_marked[org]) continue;
         origin_marked[org] = 1'b1;
         in_cycle = '0;
         hi = 0;
         node = org;
         for (int s = 0; s < NUM_PROC; s++) begin
            in_cycle[node] = 1'b1;
            if (node > hi) hi = node;
            if (!wait_entry[node][PID_W]) break;
            node = wait_entry[node][PID_W-1:0];
            if (node == org) break;
         end
         for (int i = 0; i < NUM_PROC; i++) begin
            if (in_cycle[i] && batch.size() < MAX_WORDS) begin
               w = '0;
               w.found = 1'b1;
               w.member = PID_W'(i);
               w.origin = PID_W'(org);
               w.closes_cycle = (i == hi);
               batch.push_back(w);
            end
         end
      end
      if (batch.size() == 0) begin
         w = '0;
         w.final_word = 1'b1;
         awaited_words.push_back(w);
      end else begin
         foreach (batch[k]) begin
            w = batch[k];
            w.final_word = (k == batch.size() - 1);
            awaited_words.push_back(w);
         end
      end
   endtask

   always @(posedge clock) begin
      cycle_word_type w;
      if (reset) begin
         foreach (wait_entry[i]) begin
            wait_entry[i] = '0;
            origin_marked[i] = 1'b0;
         end
         awaited_words.delete();
         mismatches = 0;
         outstanding <= 0;
      end else begin
         // predict on every accepted request word
         if (req_valid === 1'b1 && req_ready === 1'b1) begin
            if (req_mode) begin
               predict_detect();
            end else begin
               if (!req_waiting)
                  wait_entry[req_process_id] = '0;
               else
                  wait_entry[req_process_id] = {1'b1, req_waits_on};
               w = '0;
               w.final_word = 1'b1;
               awaited_words.push_back(w);
            end
         end
         // compare every accepted result word with the oldest expectation
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (awaited_words.size() == 0) begin
               report_mismatch($sformatf("result word with none expected (member %0d)",
                                         rsp_member));
            end else begin
               w = awaited_words.pop_front();
               if (rsp_found !== w.found)
                  report_mismatch($sformatf("found %b, expected %b", rsp_found, w.found));
               if (rsp_member !== w.member)
                  report_mismatch($sformatf("member %0d, expected %0d",
                                            rsp_member, w.member));
               if (rsp_cycle_origin !== w.origin)
                  report_mismatch($sformatf("cycle_origin %0d, expected %0d",
                                            rsp_cycle_origin, w.origin));
               if (rsp_last_in_cycle !== w.closes_cycle)
                  report_mismatch($sformatf("last_in_cycle %b, expected %b",
                                            rsp_last_in_cycle, w.closes_cycle));
               if (rsp_last !== w.final_word)
                  report_mismatch($sformatf("last %b, expected %b",
                                            rsp_last, w.final_word));
            end
         end
         outstanding <= awaited_words.size();
      end
   end

endmodule

// ===== tb/wait_for_cycle_detector_test.sv =====
// Testbench top for the wait-for cycle detector: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module wait_for_cycle_detector_test import wfcd_pkg::*;;

   localparam int RANDOM_WORDS = 480;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic             req_mode;
   logic [PID_W-1:0] req_process_id;
   logic [PID_W-1:0] req_waits_on;
   logic             req_waiting;
   logic             rsp_valid;
   logic             rsp_ready;
   logic             rsp_found;
   logic [PID_W-1:0] rsp_member;
   logic [PID_W-1:0] rsp_cycle_origin;
   logic             rsp_last_in_cycle;
   logic             rsp_last;
   int               mismatches;
   int               outstanding;

   int               words_sent = 0;
   logic             req_calm = 1'b0;
   logic             rsp_calm = 1'b0;

   wait_for_cycle_detector dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_process_id    (req_process_id),
      .req_waits_on      (req_waits_on),
      .req_waiting       (req_waiting),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_member        (rsp_member),
      .rsp_cycle_origin  (rsp_cycle_origin),
      .rsp_last_in_cycle (rsp_last_in_cycle),
      .rsp_last          (rsp_last)
   );

   wait_for_cycle_checker scoreboard (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_process_id    (req_process_id),
      .req_waits_on      (req_waits_on),
      .req_waiting       (req_waiting),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_member        (rsp_member),
      .rsp_cycle_origin  (rsp_cycle_origin),
      .rsp_last_in_cycle (rsp_last_in_cycle),
      .rsp_last          (rsp_last),
      .mismatches        (mismatches),
      .outstanding       (outstanding)
   );

   // 4 ns clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Offer one request word after a random gap and hold it until taken
   task automatic send_word(input logic mode, input logic [PID_W-1:0] pid,
                            input logic [PID_W-1:0] target, input logic wait_bit);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_process_id <= pid;
      req_waits_on   <= target;
      req_waiting    <= wait_bit;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      words_sent++;
      if (words_sent % 32 == 0) req_calm = ($urandom_range(0, 3) == 0);
   endtask

   // Result side: stall a random number of cycles before each word
   initial begin
      int gap;
      int taken;
      taken = 0;
      forever begin
         gap = rsp_calm ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         taken++;
         if (taken % 32 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
      end
   end

   // Stimulus and verdict
   initial begin
      int perm [NUM_PROC];
      int len;
      int kind;
      int cut;
      int j;
      int tmp;
      int count;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_mode       <= 1'b0;
      req_process_id <= '0;
      req_waits_on   <= '0;
      req_waiting    <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, self waits at both ends, a two-member cycle
      // entered from a tail, a tail into a finished walk, repeats and edits
      send_word(1'b1, 4'd0, 4'd0, 1'b0);
      send_word(1'b0, 4'd0, 4'd0, 1'b1);
      send_word(1'b0, 4'd15, 4'd15, 1'b1);
      send_word(1'b0, 4'd3, 4'd5, 1'b1);
      send_word(1'b0, 4'd5, 4'd3, 1'b1);
      send_word(1'b0, 4'd1, 4'd5, 1'b1);
      send_word(1'b0, 4'd7, 4'd3, 1'b1);
      send_word(1'b1, 4'd15, 4'd15, 1'b1);
      send_word(1'b1, 4'd0, 4'd0, 1'b0);
      send_word(1'b0, 4'd5, 4'd15, 1'b0);
      send_word(1'b0, 4'd5, 4'd3, 1'b1);
      send_word(1'b1, 4'd9, 4'd6, 1'b1);
      send_word(1'b0, 4'd1, 4'd10, 1'b0);
      send_word(1'b1, 4'd6, 4'd9, 1'b0);
      send_word(1'b0, 4'd15, 4'd0, 1'b0);
      send_word(1'b1, 4'd15, 4'd0, 1'b1);

      // Random episodes: mostly well-formed cycles with tails, otherwise noise
      // or chains with one broken link
      count = words_sent;
      while (words_sent < count + RANDOM_WORDS) begin
         foreach (perm[i]) perm[i] = i;
         for (int k = NUM_PROC - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = perm[k];
            perm[k] = perm[j];
            perm[j] = tmp;
         end
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            len = ($urandom_range(0, 19) == 0) ? NUM_PROC : $urandom_range(1, 5);
            for (int k = 0; k < len; k++)
               send_word(1'b0, PID_W'(perm[k]), PID_W'(perm[(k + 1) % len]), 1'b1);
            if (len < NUM_PROC) begin
               tmp = $urandom_range(0, 2);
               for (int t = 0; t < tmp; t++)
                  send_word(1'b0, PID_W'(perm[$urandom_range(len, NUM_PROC - 1)]),
                            PID_W'(perm[$urandom_range(0, len - 1)]), 1'b1);
            end
            send_word(1'b1, PID_W'($urandom), PID_W'($urandom), 1'($urandom));
         end else if (kind < 8) begin
            tmp = $urandom_range(1, 6);
            for (int t = 0; t < tmp; t++)
               send_word(1'b0, PID_W'($urandom), PID_W'($urandom),
                         ($urandom_range(0, 3) != 0));
            if ($urandom_range(0, 1))
               send_word(1'b1, PID_W'($urandom), PID_W'($urandom), 1'($urandom));
         end else begin
            len = $urandom_range(2, 6);
            cut = $urandom_range(0, len - 1);
            for (int k = 0; k < len; k++) begin
               if (k == cut)
                  send_word(1'b0, PID_W'(perm[k]), PID_W'($urandom), 1'b0);
               else
                  send_word(1'b0, PID_W'(perm[k]), PID_W'(perm[(k + 1) % len]), 1'b1);
            end
            send_word(1'b1, PID_W'($urandom), PID_W'($urandom), 1'($urandom));
         end
      end
      req_valid <= 1'b0;

      // Drain: let the checker see the last word, then wait out the queue
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog
   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
